>>> rtl/pdll_pkg.sv
// ----------------------------------------------------------------------------
// pdll_pkg
// Types and constants for the positional doubly linked list unit.
// ----------------------------------------------------------------------------
`default_nettype none
package pdll_pkg;
  localparam int CAPACITY = 32;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [5:0] NIL_LINK = 6'd63;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_DELETE     = 3'd5,
    CMD_READ       = 3'd6,
    CMD_NONE       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WALK, S_INS_LINK, S_DEL_READ, S_DEL_LINK, S_READ, S_OUT, S_WAIT,
    S_WAIT_W
  } state_t;
endpackage
`default_nettype wire

>>> rtl/positional_doubly_linked_list_unit.sv
// ----------------------------------------------------------------------------
// positional_doubly_linked_list_unit
// Bounded doubly linked list of 32-bit values in a node memory with a
// free-index stack.
// ----------------------------------------------------------------------------
// A failing command gives its result item straight after decode; a push goes through
// the walk and link states, a pop through walk, read and link; positional commands first
// walk up to CAPACITY - 1 links; read out gives the items one by one, each after its read.
// One command at a time; the next item is taken the cycle after the last result.
// Reset: list empty; a clearing pass fills the free stack with every node index,
// during which no item is accepted.
`default_nettype none
module positional_doubly_linked_list_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // command[2:0], position[8:3], item_value[40:9]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // status[1:0], out_value[33:2], length[39:34]
  output logic             m_tlast
);
  import pdll_pkg::*;

  logic [31:0] val_mem [CAPACITY];
  logic [5:0]  nxt_mem [CAPACITY];
  logic [5:0]  prv_mem [CAPACITY];
  logic [IDX_W-1:0] free_mem [CAPACITY];

  state_t state, state_next;
  logic [5:0] head, tail, count, free_top;
  logic [2:0] cmd;
  logic [5:0] pos, steps, cur, node, bef, aft;
  logic [31:0] ival;
  logic [31:0] rd_val;
  logic [5:0]  rd_nxt, rd_prv;
  logic [IDX_W-1:0] rd_free;
  logic [5:0] rd_addr;
  logic [1:0] o_status;
  logic [31:0] o_value;
  logic o_last;
  logic [5:0] k;
  logic is_ins;
  logic ins_full, ins_bad, del_empty, del_bad;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {count, o_value, o_status};
  assign m_tlast  = o_last;

  assign ins_full  = (count >= 6'(CAPACITY)) || (free_top == '0);
  assign ins_bad   = (cmd_t'(cmd) == CMD_INSERT) &&
                     (pos == '0 || {1'b0, pos} > {1'b0, count} + 7'd1);
  assign del_empty = (count == '0);
  assign del_bad   = (cmd_t'(cmd) == CMD_DELETE) && (pos == '0 || pos > count);

  // synchronous memory reads
  always_ff @(posedge clk) begin
    rd_val  <= val_mem[rd_addr[IDX_W-1:0]];
    rd_nxt  <= nxt_mem[rd_addr[IDX_W-1:0]];
    rd_prv  <= prv_mem[rd_addr[IDX_W-1:0]];
    rd_free <= free_mem[free_top[IDX_W-1:0] - IDX_W'(1)];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:     if (free_top == 6'(CAPACITY)) state_next = S_IDLE;
      S_IDLE:     if (s_tvalid) state_next = S_WAIT;
      S_WAIT: begin
        unique case (cmd_t'(cmd))
          CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT:
            state_next = (ins_full || ins_bad) ? S_OUT : S_WALK;
          CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE:
            state_next = (del_empty || del_bad) ? S_OUT : S_WALK;
          CMD_READ: state_next = del_empty ? S_OUT : S_READ;
          default:  state_next = S_OUT;
        endcase
      end
      S_WALK: begin
        if (steps != '0) state_next = S_WAIT_W;
        else if (is_ins) state_next = S_INS_LINK;
        else state_next = S_DEL_READ;
      end
      S_WAIT_W:   state_next = S_WALK;
      S_INS_LINK: state_next = S_OUT;
      S_DEL_READ: state_next = S_DEL_LINK;
      S_DEL_LINK: state_next = S_OUT;
      S_READ:     state_next = S_OUT;
      S_OUT: begin
        if (m_tready) begin
          if (cmd_t'(cmd) == CMD_READ && count != '0 && !o_last) state_next = S_READ;
          else state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; head <= NIL_LINK; tail <= NIL_LINK; count <= '0;
      free_top <= '0; rd_addr <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_INIT: begin
          if (free_top != 6'(CAPACITY)) begin
            free_mem[free_top[IDX_W-1:0]] <= free_top[IDX_W-1:0];
            free_top <= free_top + 6'd1;
          end
        end
        S_IDLE: if (s_tvalid) begin
          cmd  <= s_tdata[2:0];
          pos  <= s_tdata[8:3];
          ival <= s_tdata[40:9];
          rd_addr <= head;
        end
        S_WAIT: begin
          // decode and check
          o_value <= '0; o_last <= 1'b1;
          k <= '0;
          unique case (cmd_t'(cmd))
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
              is_ins <= 1'b1;
              o_status <= ins_full ? ST_FULL : ins_bad ? ST_RANGE : ST_OK;
              if (!ins_full && !ins_bad) begin
                // node index from free stack is in rd_free
                node <= {{(6-IDX_W){1'b0}}, rd_free};
                free_top <= free_top - 6'd1;
                steps <= (cmd_t'(cmd) == CMD_INSERT) ? pos - 6'd1 : 6'd0;
                bef <= (cmd_t'(cmd) == CMD_PUSH_BACK) ? tail : NIL_LINK;
                cur <= (cmd_t'(cmd) == CMD_PUSH_BACK) ? NIL_LINK : head;
                rd_addr <= head;
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE: begin
              is_ins <= 1'b0;
              o_status <= del_empty ? ST_EMPTY : del_bad ? ST_RANGE : ST_OK;
              if (!del_empty && !del_bad) begin
                steps <= (cmd_t'(cmd) == CMD_DELETE) ? pos - 6'd1 : 6'd0;
                cur <= (cmd_t'(cmd) == CMD_POP_BACK) ? tail : head;
                rd_addr <= (cmd_t'(cmd) == CMD_POP_BACK) ? tail : head;
              end
            end
            CMD_READ: begin
              o_status <= del_empty ? ST_EMPTY : ST_OK;
              if (!del_empty) begin
                cur <= head; rd_addr <= head;
              end
            end
            default: o_status <= ST_OK;
          endcase
        end
        S_WALK: begin
          // rd_* hold entry cur (read issued last cycle)
          if (steps == '0) begin
            if (is_ins) begin
              // insert between bef and cur
              aft <= cur;
              val_mem[node[IDX_W-1:0]] <= ival;
              prv_mem[node[IDX_W-1:0]] <= bef;
              nxt_mem[node[IDX_W-1:0]] <= cur;
            end
          end else begin
            steps <= steps - 6'd1;
            bef <= cur;
            cur <= rd_nxt; rd_addr <= rd_nxt;
          end
        end
        S_INS_LINK: begin
          if (bef == NIL_LINK) head <= node;
          else nxt_mem[bef[IDX_W-1:0]] <= node;
          if (aft == NIL_LINK) tail <= node;
          else prv_mem[aft[IDX_W-1:0]] <= node;
          count <= count + 6'd1;
        end
        S_DEL_READ: begin
          o_value <= rd_val;
          bef <= rd_prv; aft <= rd_nxt;
          if (rd_prv == NIL_LINK) head <= rd_nxt;
          else nxt_mem[rd_prv[IDX_W-1:0]] <= rd_nxt;
        end
        S_DEL_LINK: begin
          if (aft == NIL_LINK) tail <= bef;
          else prv_mem[aft[IDX_W-1:0]] <= bef;
          free_mem[free_top[IDX_W-1:0]] <= cur[IDX_W-1:0];
          free_top <= free_top + 6'd1;
          count <= count - 6'd1;
        end
        S_READ: begin
          o_value <= rd_val;
          o_last <= (k + 6'd1 == count) || rd_nxt == NIL_LINK;
          cur <= rd_nxt; rd_addr <= rd_nxt;
          k <= k + 6'd1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/pdll_checker.sv
// ----------------------------------------------------------------------------
// pdll_checker
// Port-level checks for the positional doubly linked list unit.
// ----------------------------------------------------------------------------
`default_nettype none
module pdll_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input taken while result pending");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tlast && m_tdata[33:2] == 32'd0)
    else $error("failing command with data");
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:34] <= 6'd32) else $error("length above capacity");
endmodule

bind positional_doubly_linked_list_unit pdll_checker u_pdll_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

>>> bench/tb_positional_doubly_linked_list_unit.sv
// ----------------------------------------------------------------------------
// tb_positional_doubly_linked_list_unit
// Drives list commands from a pending queue with random idle bursts on both
// sides, keeps a shadow list to work out the expected result items, and
// compares every result item field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_positional_doubly_linked_list_unit;
  import pdll_pkg::*;

  typedef struct packed {
    cmd_t        command;
    logic [5:0]  position;
    logic [31:0] item_value;
  } cmd_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] out_value;
    logic [5:0]  length;
    logic        last;
  } list_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  positional_doubly_linked_list_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  cmd_item_t    pending_cmds[$];
  list_result_t expected_results[$];
  logic [31:0]  shadow_list[$];
  int           error_count;
  int           stall_cycles;
  bit           calm;
  int           send_gap;
  int           recv_gap;

  localparam int WATCHDOG_LIMIT = 20000;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    error_count++;
  endtask

  task automatic predict_list_results(input cmd_item_t c);
    int cnt;
    int p;
    logic [31:0] got;
    cnt = shadow_list.size();
    p = int'(c.position);
    case (c.command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        if (cnt >= CAPACITY) begin
          expected_results.push_back('{ST_FULL, 32'd0, 6'(cnt), 1'b1});
        end else if (c.command == CMD_INSERT && (p < 1 || p > cnt + 1)) begin
          expected_results.push_back('{ST_RANGE, 32'd0, 6'(cnt), 1'b1});
        end else begin
          if (c.command == CMD_PUSH_FRONT) p = 1;
          else if (c.command == CMD_PUSH_BACK) p = cnt + 1;
          shadow_list.insert(p - 1, c.item_value);
          expected_results.push_back('{ST_OK, 32'd0, 6'(cnt + 1), 1'b1});
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE: begin
        if (cnt == 0) begin
          expected_results.push_back('{ST_EMPTY, 32'd0, 6'd0, 1'b1});
        end else if (c.command == CMD_DELETE && (p < 1 || p > cnt)) begin
          expected_results.push_back('{ST_RANGE, 32'd0, 6'(cnt), 1'b1});
        end else begin
          if (c.command == CMD_POP_FRONT) p = 1;
          else if (c.command == CMD_POP_BACK) p = cnt;
          got = shadow_list[p - 1];
          shadow_list.delete(p - 1);
          expected_results.push_back('{ST_OK, got, 6'(cnt - 1), 1'b1});
        end
      end
      CMD_READ: begin
        if (cnt == 0) expected_results.push_back('{ST_EMPTY, 32'd0, 6'd0, 1'b1});
        for (int k = 0; k < cnt; k++)
          expected_results.push_back('{ST_OK, shadow_list[k], 6'(cnt), k == cnt - 1});
      end
      default: expected_results.push_back('{ST_OK, 32'd0, 6'(cnt), 1'b1});
    endcase
  endtask

  function automatic cmd_item_t make_cmd(input cmd_t op, input int pos, input logic [31:0] v);
    cmd_item_t c;
    c.command = op;
    c.position = 6'(pos);
    c.item_value = v;
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_list_results(pending_cmds.pop_front());
      if (s_tvalid && !s_tready) begin
        // hold
      end else if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        s_tvalid <= 1'b0;
        send_gap <= $urandom_range(0, 11);
      end else if (pending_cmds.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, pending_cmds[0].item_value, pending_cmds[0].position,
                    pending_cmds[0].command};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
      stall_cycles <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result item %h", m_tdata));
        end else begin
          exp_r = expected_results.pop_front();
          if (m_tdata[1:0] !== exp_r.status)
            report_mismatch($sformatf("status %0d exp %0d", m_tdata[1:0], exp_r.status));
          if (m_tdata[33:2] !== exp_r.out_value)
            report_mismatch($sformatf("out_value %h exp %h", m_tdata[33:2], exp_r.out_value));
          if (m_tdata[39:34] !== exp_r.length)
            report_mismatch($sformatf("length %0d exp %0d", m_tdata[39:34], exp_r.length));
          if (m_tlast !== exp_r.last)
            report_mismatch($sformatf("last %b exp %b", m_tlast, exp_r.last));
        end
      end
      if (recv_gap > 0) begin
        m_tready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        recv_gap <= $urandom_range(0, 11);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    cmd_item_t c;
    int r;
    int len_est;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    error_count = 0;
    stall_cycles = 0;
    calm = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_POP_FRONT, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_POP_BACK, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 1, 0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 32'h1));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 2, 32'h2));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 1, 32'h7fffffff));
    pending_cmds.push_back(make_cmd(CMD_PUSH_FRONT, 63, 32'h80000000));
    pending_cmds.push_back(make_cmd(CMD_PUSH_BACK, 0, 32'hffffffff));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 4, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 6, 32'h5a5a5a5a));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 63, 32'h3));
    pending_cmds.push_back(make_cmd(CMD_NONE, 63, 32'hffffffff));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 6, 0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 3, 0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 5, 0));
    pending_cmds.push_back(make_cmd(CMD_POP_FRONT, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_POP_BACK, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0));
    // fill to capacity and beyond
    for (int i = 0; i < CAPACITY; i++)
      pending_cmds.push_back(make_cmd(CMD_PUSH_BACK, 0, $urandom));
    pending_cmds.push_back(make_cmd(CMD_PUSH_FRONT, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 1, 0));
    pending_cmds.push_back(make_cmd(CMD_READ, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, CAPACITY, 0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, CAPACITY, 0));
    len_est = CAPACITY - 1;

    for (int i = 0; i < 320; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) c = make_cmd(cmd_t'($urandom_range(0, 2)),
                               $urandom_range(1, len_est + 1), $urandom);
      else if (r < 75) c = make_cmd(cmd_t'($urandom_range(3, 5)),
                                    $urandom_range(1, len_est > 0 ? len_est : 1), 0);
      else if (r < 82) c = make_cmd(CMD_READ, $urandom_range(0, 63), $urandom);
      else c = make_cmd(cmd_t'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom);
      if (c.command <= CMD_INSERT && len_est < CAPACITY) len_est++;
      else if (c.command >= CMD_POP_FRONT && c.command <= CMD_DELETE && len_est > 0) len_est--;
      if (i == 260) begin
        while (pending_cmds.size() > 0) begin
          @(posedge clk);
          if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
          end
        end
        calm = 1'b1;
      end
      pending_cmds.push_back(c);
    end

    while (pending_cmds.size() > 0 || expected_results.size() > 0) begin
      @(posedge clk);
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
